FILE: src/koct_pkg.sv
// Shared types, constants and codes of the keyed outcome counter table.
package koct_pkg;

  localparam int unsigned KEY_W = 16;
  localparam int unsigned Q_W   = 17;
  localparam int unsigned G_W   = 32;

  localparam logic [1:0] OP_RECORD   = 2'd0;
  localparam logic [1:0] OP_FEEDBACK = 2'd1;
  localparam logic [1:0] OP_QUERY    = 2'd2;
  localparam logic [1:0] OP_SPARE    = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  localparam logic [0:0] REG_THRESHOLD = 1'd0;
  localparam logic [16:0] THRESHOLD_RESET = 17'd32768;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] position;
    logic        avoided;
    logic        predicted;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] observations;
    logic [23:0] avoidances;
    logic [16:0] ratio;
    logic        predict_avoid;
    logic [16:0] global_ratio;
    logic [16:0] accuracy;
    logic [31:0] feedback_count;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH_RD,
    S_SEARCH_CMP,
    S_UPDATE,
    S_DIV_E_START,
    S_DIV_E,
    S_DIV_G_START,
    S_DIV_G,
    S_DIV_A_START,
    S_DIV_A,
    S_DONE
  } state_t;

  // Divider handshake between the sequencer and the shared divider.
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] quot;
  } div_rsp_t;

endpackage

FILE: src/koct_div.sv
// Restoring divider computing floor((num << 16) / den) truncated to its low 17 bits, one bit a cycle.
module koct_div (
  input  logic              clk,
  input  logic              rst_n,
  input  koct_pkg::div_req_t req,
  output koct_pkg::div_rsp_t rsp
);

  // The quotient of a ratio within range never exceeds 17 bits; the caller
  // only divides num <= den, so 17 quotient bits are all that is needed.
  logic [47:0] rem_r, rem_nxt;
  logic [47:0] num_r, num_nxt;
  logic [31:0] den_r, den_nxt;
  logic [16:0] quot_r, quot_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [48:0] trial;

  always_comb begin
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = '0;
    if (req.start) begin
      rem_nxt  = '0;
      num_nxt  = {req.num, 16'd0};
      den_nxt  = req.den;
      quot_nxt = '0;
      cnt_nxt  = 6'd48;
      busy_nxt = (req.den != 32'd0);
      done_nxt = (req.den == 32'd0);
    end else if (busy_r) begin
      trial   = {rem_r, num_r[47]} - {17'd0, den_r};
      num_nxt = {num_r[46:0], 1'b0};
      if (!trial[48]) begin
        rem_nxt  = trial[47:0];
        quot_nxt = {quot_r[15:0], 1'b1};
      end else begin
        rem_nxt  = {rem_r[46:0], num_r[47]};
        quot_nxt = {quot_r[15:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

FILE: src/koct_mem.sv
// Entry store: key and both counters per entry, one write and one registered read port.
module koct_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned CW    = 24,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic [AW-1:0]             rd_addr,
  output logic [koct_pkg::KEY_W-1:0] rd_key,
  output logic [CW-1:0]             rd_obs,
  output logic [CW-1:0]             rd_avd,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [koct_pkg::KEY_W-1:0] wr_key,
  input  logic [CW-1:0]             wr_obs,
  input  logic [CW-1:0]             wr_avd
);

  logic [koct_pkg::KEY_W+2*CW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_key, wr_obs, wr_avd};
    end
    {rd_key, rd_obs, rd_avd} <= mem[rd_addr];
  end

endmodule

FILE: src/keyed_outcome_counter_table.sv
// Top level of the keyed outcome counter table: sequencer, totals and result register.
//
// Usage: raise start with the in_item payload while busy is low; the
// transaction is accepted at that edge and busy rises. The sequencer
// searches the entry store linearly, each entry taking a read state and a
// compare state, since the read port is registered. The entry is then
// updated in S_UPDATE and three ratios go in turn through one shared
// restoring divider, which skips its iterations and gives zero when the
// denominator is zero. The result follows the last ratio, and busy falls
// in the cycle after the result.
// The result appears on out_item for exactly one cycle with out_valid high;
// the receiver cannot stall it, so it must take it in that cycle.
// The threshold register sits at APB address 0; pready is always high.
// Reset (rst_n low, synchronous) empties the table, zeroes all totals and
// sets the threshold to 32768. Entry contents are not cleared: only entries
// below the fill count are ever read.
module keyed_outcome_counter_table #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned COUNT_BITS    = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  koct_pkg::in_item_t  in_item,
  output logic                out_valid,
  output koct_pkg::out_item_t out_item,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [0:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned UW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;
  localparam logic [UW-1:0] FULL = UW'(TABLE_ENTRIES);

  koct_pkg::state_t state_r, state_nxt;
  koct_pkg::in_item_t item_r;
  logic [16:0] thr_r;
  logic [UW-1:0] used_r, used_nxt;
  logic [UW-1:0] idx_r, idx_nxt;
  logic          found_r, found_nxt;
  logic [31:0] gobs_r, gobs_nxt, gavd_r, gavd_nxt, fbt_r, fbt_nxt, cor_r, cor_nxt;
  logic [COUNT_BITS-1:0] obs_r, obs_nxt, avd_r, avd_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [16:0] ratio_r, gratio_r, acc_r;
  logic        out_valid_r;

  logic [koct_pkg::KEY_W-1:0] rd_key;
  logic [COUNT_BITS-1:0] rd_obs, rd_avd;
  logic          wr_en;
  logic [AW-1:0] rd_addr;
  koct_pkg::div_req_t dreq;
  koct_pkg::div_rsp_t drsp;

  logic write_cfg;
  assign write_cfg  = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == koct_pkg::REG_THRESHOLD) ? {15'd0, thr_r} : 32'd0;

  assign rd_addr = idx_r[AW-1:0];

  koct_mem #(.DEPTH(TABLE_ENTRIES), .CW(COUNT_BITS)) u_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_key  (rd_key),
    .rd_obs  (rd_obs),
    .rd_avd  (rd_avd),
    .wr_en   (wr_en),
    .wr_addr (idx_r[AW-1:0]),
    .wr_key  (item_r.position),
    .wr_obs  (obs_nxt),
    .wr_avd  (avd_nxt)
  );

  koct_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  logic is_count;
  logic twice;
  assign is_count = (item_r.operation == koct_pkg::OP_RECORD) ||
                    (item_r.operation == koct_pkg::OP_FEEDBACK);
  assign twice = (item_r.operation == koct_pkg::OP_FEEDBACK) &&
                 (item_r.predicted != item_r.avoided);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      koct_pkg::S_IDLE:       if (start) state_nxt = koct_pkg::S_SEARCH_RD;
      koct_pkg::S_SEARCH_RD: begin
        if (idx_r >= used_r) state_nxt = koct_pkg::S_UPDATE;
        else state_nxt = koct_pkg::S_SEARCH_CMP;
      end
      koct_pkg::S_SEARCH_CMP: begin
        if (rd_key == item_r.position) state_nxt = koct_pkg::S_UPDATE;
        else state_nxt = koct_pkg::S_SEARCH_RD;
      end
      koct_pkg::S_UPDATE:      state_nxt = koct_pkg::S_DIV_E_START;
      koct_pkg::S_DIV_E_START: state_nxt = koct_pkg::S_DIV_E;
      koct_pkg::S_DIV_E:       if (drsp.done) state_nxt = koct_pkg::S_DIV_G_START;
      koct_pkg::S_DIV_G_START: state_nxt = koct_pkg::S_DIV_G;
      koct_pkg::S_DIV_G:       if (drsp.done) state_nxt = koct_pkg::S_DIV_A_START;
      koct_pkg::S_DIV_A_START: state_nxt = koct_pkg::S_DIV_A;
      koct_pkg::S_DIV_A:       if (drsp.done) state_nxt = koct_pkg::S_DONE;
      koct_pkg::S_DONE:        state_nxt = koct_pkg::S_IDLE;
      default:                 state_nxt = koct_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    logic [2:0] n;
    logic [COUNT_BITS:0] so, sa;
    logic [2:0] go, ga;
    idx_nxt    = idx_r;
    found_nxt  = found_r;
    used_nxt   = used_r;
    gobs_nxt   = gobs_r;
    gavd_nxt   = gavd_r;
    fbt_nxt    = fbt_r;
    cor_nxt    = cor_r;
    obs_nxt    = obs_r;
    avd_nxt    = avd_r;
    status_nxt = status_r;
    wr_en      = 1'b0;
    dreq       = '0;
    n  = twice ? 3'd3 : 3'd1;
    so = '0;
    sa = '0;
    go = '0;
    ga = '0;
    unique case (state_r)
      koct_pkg::S_IDLE: begin
        idx_nxt   = '0;
        found_nxt = 1'b0;
      end
      koct_pkg::S_SEARCH_CMP: begin
        if (rd_key == item_r.position) begin
          found_nxt = 1'b1;
          obs_nxt   = rd_obs;
          avd_nxt   = rd_avd;
        end else begin
          idx_nxt = idx_r + UW'(1);
        end
      end
      koct_pkg::S_UPDATE: begin
        status_nxt = koct_pkg::ST_OK;
        if (item_r.operation == koct_pkg::OP_FEEDBACK) begin
          if (fbt_r != '1) fbt_nxt = fbt_r + 32'd1;
          if (item_r.predicted == item_r.avoided && cor_r != '1) cor_nxt = cor_r + 32'd1;
        end
        if (!found_r) begin
          obs_nxt = '0;
          avd_nxt = '0;
        end
        if (is_count) begin
          if (!found_r && used_r == FULL) begin
            status_nxt = koct_pkg::ST_FULL;
          end else begin
            if (!found_r) begin
              used_nxt = used_r + UW'(1);
              so = '0;
              sa = '0;
            end else begin
              so = {1'b0, obs_r};
              sa = {1'b0, avd_r};
            end
            // Saturating increment by n, counting how many steps really happened.
            if (so + (COUNT_BITS+1)'(n) > {1'b0, CMAX}) go = 3'(CMAX - so[COUNT_BITS-1:0]);
            else go = n;
            if (!item_r.avoided) ga = '0;
            else if (sa + (COUNT_BITS+1)'(n) > {1'b0, CMAX})
              ga = 3'(CMAX - sa[COUNT_BITS-1:0]);
            else ga = n;
            obs_nxt = so[COUNT_BITS-1:0] + COUNT_BITS'(go);
            avd_nxt = sa[COUNT_BITS-1:0] + COUNT_BITS'(ga);
            gobs_nxt = (gobs_r > 32'hFFFF_FFFF - 32'(go)) ? '1 : gobs_r + 32'(go);
            gavd_nxt = (gavd_r > 32'hFFFF_FFFF - 32'(ga)) ? '1 : gavd_r + 32'(ga);
            wr_en = 1'b1;
          end
        end else if (!found_r) begin
          status_nxt = koct_pkg::ST_NOT_FOUND;
        end
      end
      koct_pkg::S_DIV_E_START: begin
        dreq.start = 1'b1;
        dreq.num   = 32'(avd_r);
        dreq.den   = 32'(obs_r);
      end
      koct_pkg::S_DIV_G_START: begin
        dreq.start = 1'b1;
        dreq.num   = gavd_r;
        dreq.den   = gobs_r;
      end
      koct_pkg::S_DIV_A_START: begin
        dreq.start = 1'b1;
        dreq.num   = cor_r;
        dreq.den   = fbt_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == koct_pkg::S_IDLE && start) item_r <= in_item;
    obs_r    <= obs_nxt;
    avd_r    <= avd_nxt;
    status_r <= status_nxt;
    if (state_r == koct_pkg::S_DIV_E && drsp.done) ratio_r  <= drsp.quot;
    if (state_r == koct_pkg::S_DIV_G && drsp.done) gratio_r <= drsp.quot;
    if (state_r == koct_pkg::S_DIV_A && drsp.done) acc_r    <= drsp.quot;
    if (!rst_n) begin
      state_r     <= koct_pkg::S_IDLE;
      thr_r       <= koct_pkg::THRESHOLD_RESET;
      used_r      <= '0;
      idx_r       <= '0;
      found_r     <= 1'b0;
      gobs_r      <= '0;
      gavd_r      <= '0;
      fbt_r       <= '0;
      cor_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      gobs_r      <= gobs_nxt;
      gavd_r      <= gavd_nxt;
      fbt_r       <= fbt_nxt;
      cor_r       <= cor_nxt;
      out_valid_r <= (state_r == koct_pkg::S_DIV_A) && drsp.done;
      if (write_cfg && cfg_paddr == koct_pkg::REG_THRESHOLD) thr_r <= cfg_pwdata[16:0];
    end
  end

  assign busy      = (state_r != koct_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    out_item.status         = status_r;
    out_item.observations   = 24'(obs_r);
    out_item.avoidances     = 24'(avd_r);
    out_item.ratio          = ratio_r;
    out_item.predict_avoid  = (ratio_r >= thr_r);
    out_item.global_ratio   = gratio_r;
    out_item.accuracy       = acc_r;
    out_item.feedback_count = fbt_r;
  end

endmodule

FILE: verif/keyed_outcome_counter_table_tb.sv
// Self-checking testbench for the keyed outcome counter table, with its scoreboard class.
module keyed_outcome_counter_table_tb;

  localparam int unsigned N_ENTRIES = 64;
  localparam int unsigned CNT_BITS  = 24;
  localparam logic [31:0] CNT_MAX   = (32'd1 << CNT_BITS) - 32'd1;
  localparam int unsigned HALF_CYCLE = 4;

  class outcome_scoreboard;
    logic [15:0] keys [N_ENTRIES];
    logic [31:0] obs_cnt [N_ENTRIES];
    logic [31:0] avd_cnt [N_ENTRIES];
    int unsigned used;
    logic [31:0] glob_obs, glob_avd, fb_total, fb_correct;
    logic [16:0] threshold;
    koct_pkg::out_item_t pending [$];
    int unsigned n_mismatch;

    function new();
      used = 0;
      glob_obs = 0;
      glob_avd = 0;
      fb_total = 0;
      fb_correct = 0;
      threshold = koct_pkg::THRESHOLD_RESET;
      n_mismatch = 0;
    endfunction

    function logic [16:0] q16(logic [31:0] num, logic [31:0] den);
      logic [63:0] wide;
      if (den == 0) return 17'd0;
      wide = ({32'd0, num} << 16) / {32'd0, den};
      return wide[16:0];
    endfunction

    function logic [31:0] inc_sat(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function void tally(int idx, logic avd);
      if (obs_cnt[idx] < CNT_MAX) begin
        obs_cnt[idx]++;
        glob_obs = inc_sat(glob_obs);
      end
      if (avd && avd_cnt[idx] < CNT_MAX) begin
        avd_cnt[idx]++;
        glob_avd = inc_sat(glob_avd);
      end
    endfunction

    // Works out the result of one accepted transaction and queues it.
    function void note_input(koct_pkg::in_item_t it);
      int idx;
      koct_pkg::out_item_t res;
      idx = -1;
      res = '0;
      for (int i = 0; i < used; i++) begin
        if (idx < 0 && keys[i] == it.position) idx = i;
      end
      if (it.operation == koct_pkg::OP_RECORD || it.operation == koct_pkg::OP_FEEDBACK) begin
        if (it.operation == koct_pkg::OP_FEEDBACK) begin
          fb_total = inc_sat(fb_total);
          if (it.predicted == it.avoided) fb_correct = inc_sat(fb_correct);
        end
        if (idx < 0) begin
          if (used < N_ENTRIES) begin
            idx = used;
            keys[idx] = it.position;
            obs_cnt[idx] = 0;
            avd_cnt[idx] = 0;
            used++;
          end else begin
            res.status = koct_pkg::ST_FULL;
          end
        end
        if (idx >= 0) begin
          tally(idx, it.avoided);
          // A wrong prediction weighs the actual outcome three times.
          if (it.operation == koct_pkg::OP_FEEDBACK && it.predicted != it.avoided) begin
            tally(idx, it.avoided);
            tally(idx, it.avoided);
          end
        end
      end else if (idx < 0) begin
        res.status = koct_pkg::ST_NOT_FOUND;
      end
      if (idx >= 0) begin
        res.observations = obs_cnt[idx][23:0];
        res.avoidances = avd_cnt[idx][23:0];
      end
      res.ratio = q16({8'd0, res.avoidances}, {8'd0, res.observations});
      res.predict_avoid = (res.ratio >= threshold);
      res.global_ratio = q16(glob_avd, glob_obs);
      res.accuracy = q16(fb_correct, fb_total);
      res.feedback_count = fb_total;
      pending.push_back(res);
    endfunction

    function void check_result(koct_pkg::out_item_t got);
      koct_pkg::out_item_t exp_res;
      if (pending.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result: %p", got);
        return;
      end
      exp_res = pending.pop_front();
      if (got !== exp_res) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("result mismatch: expected %p, got %p", exp_res, got);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  koct_pkg::in_item_t  in_item;
  logic        out_valid;
  koct_pkg::out_item_t out_item;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [0:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        cfg_pready;

  outcome_scoreboard sb;

  keyed_outcome_counter_table dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial clk = 1'b0;
  always #(HALF_CYCLE) clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_item);
  end

  task automatic send_item(koct_pkg::in_item_t it);
    @(negedge clk);
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    sb.note_input(it);
  endtask

  task automatic pause_sender(int unsigned cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Threshold writes happen only with nothing in flight.
  task automatic write_threshold(logic [16:0] value);
    pause_sender(0);
    drain();
    @(negedge clk);
    while (busy) @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= koct_pkg::REG_THRESHOLD;
    cfg_pwdata <= {15'd0, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    sb.threshold = value;
  endtask

  function automatic koct_pkg::in_item_t make_item(logic [1:0] op, logic [15:0] key,
                                                   logic avd, logic pred);
    koct_pkg::in_item_t it;
    it.operation = op;
    it.position = key;
    it.avoided = avd;
    it.predicted = pred;
    return it;
  endfunction

  function automatic koct_pkg::in_item_t random_item();
    int unsigned pick;
    logic [1:0] op;
    logic [15:0] key;
    pick = $urandom_range(0, 99);
    if (pick < 40) op = koct_pkg::OP_RECORD;
    else if (pick < 75) op = koct_pkg::OP_FEEDBACK;
    else if (pick < 95) op = koct_pkg::OP_QUERY;
    else op = koct_pkg::OP_SPARE;
    // A small pool of keys so that entries fill up and get revisited.
    if ($urandom_range(0, 9) == 0) key = 16'($urandom);
    else key = 16'($urandom_range(0, 79) * 919);
    return make_item(op, key, 1'($urandom), 1'($urandom));
  endfunction

  task automatic random_phase(int unsigned count);
    int unsigned done_cnt;
    int unsigned burst;
    done_cnt = 0;
    while (done_cnt < count) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst && done_cnt < count; b++) begin
        send_item(random_item());
        done_cnt++;
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(0, 300));
    end
  endtask

  initial begin
    logic [16:0] thresholds [4];
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: absent keys, key extremes, right and wrong feedback, spare code.
    send_item(make_item(koct_pkg::OP_QUERY, 16'h0000, 1'b0, 1'b0));
    send_item(make_item(koct_pkg::OP_SPARE, 16'hFFFF, 1'b1, 1'b1));
    send_item(make_item(koct_pkg::OP_RECORD, 16'h0000, 1'b1, 1'b0));
    send_item(make_item(koct_pkg::OP_RECORD, 16'hFFFF, 1'b0, 1'b1));
    send_item(make_item(koct_pkg::OP_FEEDBACK, 16'h0000, 1'b1, 1'b1));
    send_item(make_item(koct_pkg::OP_FEEDBACK, 16'h0000, 1'b0, 1'b1));
    send_item(make_item(koct_pkg::OP_FEEDBACK, 16'hFFFF, 1'b1, 1'b0));
    send_item(make_item(koct_pkg::OP_FEEDBACK, 16'h1234, 1'b0, 1'b0));
    send_item(make_item(koct_pkg::OP_QUERY, 16'h0000, 1'b0, 1'b0));
    send_item(make_item(koct_pkg::OP_SPARE, 16'hFFFF, 1'b0, 1'b0));
    send_item(make_item(koct_pkg::OP_QUERY, 16'h5555, 1'b1, 1'b1));
    write_threshold(17'd0);
    send_item(make_item(koct_pkg::OP_QUERY, 16'hAAAA, 1'b0, 1'b0));
    send_item(make_item(koct_pkg::OP_RECORD, 16'h8000, 1'b0, 1'b0));
    write_threshold(17'd65536);
    send_item(make_item(koct_pkg::OP_RECORD, 16'h8000, 1'b1, 1'b1));
    send_item(make_item(koct_pkg::OP_QUERY, 16'h0000, 1'b0, 1'b0));
    // Fill the table so that a new key is dropped.
    for (int k = 0; k < N_ENTRIES; k++) begin
      send_item(make_item(koct_pkg::OP_RECORD, 16'h4000 + 16'(k), 1'b1, 1'b0));
    end
    send_item(make_item(koct_pkg::OP_RECORD, 16'h7777, 1'b1, 1'b0));
    send_item(make_item(koct_pkg::OP_FEEDBACK, 16'h7778, 1'b1, 1'b0));

    thresholds[0] = koct_pkg::THRESHOLD_RESET;
    thresholds[1] = 17'd0;
    thresholds[2] = 17'd65536;
    thresholds[3] = 17'h1FFFF;
    random_phase(300);
    for (int p = 0; p < 4; p++) begin
      write_threshold(thresholds[p]);
      random_phase(220);
    end
    write_threshold(17'($urandom_range(1, 65535)));
    random_phase(220);

    pause_sender(0);
    drain();
    repeat (400) @(posedge clk);
    if (sb.n_mismatch == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(2 * HALF_CYCLE * 4_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
